// File: rtl/xeu_pkg.sv
// Shared types and constants for the XML entity unescaper.
package xeu_pkg;

   localparam int NumEnt = 5;
   localparam int MaxRun = 6;
   localparam int MaxLetters = 4;

   typedef logic [7:0] byte_type;

   // One group of output bytes caused by one accepted input byte.
   typedef struct packed {
      logic                      last;   // run ends the string
      logic [2:0]                count;  // 1..MaxRun bytes
      byte_type [MaxRun-1:0]     bytes;  // bytes[0] goes out first
   } run_type;

   localparam byte_type AmpChar = 8'h26;

   // Entity names without the leading ampersand, zero padded.
   localparam byte_type EntName [NumEnt][5] = '{
      '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // amp;
      '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // lt;
      '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},   // gt;
      '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // quot;
      '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}    // apos;
   };

   localparam logic [2:0] EntLen [NumEnt] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};

   localparam byte_type EntChar [NumEnt] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

endpackage

// File: rtl/xeu_front.sv
// Front end: matches entity prefixes and builds at most one output run per input byte.
module xeu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic                q_full,
   output logic                q_push,
   output xeu_pkg::run_type    q_run
);

   logic [2:0]          prefix_len_ff, prefix_len_in;
   xeu_pkg::byte_type   letters_ff [xeu_pkg::MaxLetters];
   xeu_pkg::byte_type   letters_in [xeu_pkg::MaxLetters];

   logic [2:0]          plen;
   logic [2:0]          nl;
   xeu_pkg::byte_type   cand [5];
   logic [xeu_pkg::NumEnt-1:0] match;
   logic                hit;
   logic                hold;
   xeu_pkg::byte_type   hit_char;
   logic                accept;
   xeu_pkg::run_type    run;

   assign accept = req_push && !q_full;
   assign plen   = (prefix_len_ff > 3'd5) ? 3'd0 : prefix_len_ff;
   assign nl     = plen - 3'd1;

   // candidate letters: held letters, then the new byte
   always_comb begin
      for (int i = 0; i < xeu_pkg::MaxLetters; i++) begin
         cand[i] = (3'(i) < nl) ? letters_ff[i] : req_in_byte;
      end
      cand[4] = req_in_byte;
   end

   always_comb begin
      logic found;
      found    = 1'b0;
      hit      = 1'b0;
      hold     = 1'b0;
      hit_char = '0;
      for (int e = 0; e < xeu_pkg::NumEnt; e++) begin
         match[e] = (3'(nl + 3'd1) <= xeu_pkg::EntLen[e]);
         for (int i = 0; i < 5; i++) begin
            if ((3'(i) <= nl) && (cand[i] != xeu_pkg::EntName[e][i])) begin
               match[e] = 1'b0;
            end
         end
      end
      // first entity in table order wins
      for (int e = 0; e < xeu_pkg::NumEnt; e++) begin
         if (match[e] && !found) begin
            found = 1'b1;
            if (3'(nl + 3'd1) == xeu_pkg::EntLen[e]) begin
               hit      = 1'b1;
               hit_char = xeu_pkg::EntChar[e];
            end else begin
               hold = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [2:0] k;
      k             = '0;
      run           = '0;
      letters_in    = letters_ff;
      prefix_len_in = plen;
      if (plen == 3'd0) begin
         if (req_in_byte == xeu_pkg::AmpChar) begin
            prefix_len_in = 3'd1;
         end else begin
            run.bytes[0] = req_in_byte;
            k            = 3'd1;
         end
      end else if (hit) begin
         run.bytes[0]  = hit_char;
         k             = 3'd1;
         prefix_len_in = 3'd0;
      end else if (hold) begin
         letters_in[nl[1:0]] = req_in_byte;
         prefix_len_in       = plen + 3'd1;
      end else begin
         // failed match: replay the ampersand and held letters, then the new byte unless it is an ampersand
         run.bytes[0] = xeu_pkg::AmpChar;
         k            = 3'd1;
         for (int i = 0; i < xeu_pkg::MaxLetters; i++) begin
            if (3'(i) < nl) begin
               run.bytes[k] = letters_ff[i];
               k            = k + 3'd1;
            end
         end
         if (req_in_byte == xeu_pkg::AmpChar) begin
            prefix_len_in = 3'd1;
         end else begin
            run.bytes[k]  = req_in_byte;
            k             = k + 3'd1;
            prefix_len_in = 3'd0;
         end
      end
      // end of string: flush whatever is still held
      if (req_in_last && (prefix_len_in != 3'd0)) begin
         if (k < 3'(xeu_pkg::MaxRun)) begin
            run.bytes[k] = xeu_pkg::AmpChar;
         end
         k = k + 3'd1;
         for (int i = 0; i < xeu_pkg::MaxLetters; i++) begin
            if ((3'(i) < 3'(prefix_len_in - 3'd1)) && (k < 3'(xeu_pkg::MaxRun))) begin
               run.bytes[k] = letters_in[i];
               k            = k + 3'd1;
            end
         end
         prefix_len_in = 3'd0;
      end
      run.count = k;
      run.last  = req_in_last;
   end

   assign q_push = accept && (run.count != 3'd0);
   assign q_run  = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff <= '0;
      end else if (accept) begin
         prefix_len_ff <= prefix_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         letters_ff <= letters_in;
      end
   end

endmodule

// File: rtl/xeu_queue.sv
// Run queue between the front end and the output sequencer.
module xeu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xeu_pkg::run_type    push_run,
   output logic                full,
   input  logic                pop,
   output xeu_pkg::run_type    pop_run,
   output logic                empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   xeu_pkg::run_type   slot_ff [DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    count_ff;
   logic               do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_run = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

// File: rtl/xeu_back.sv
// Output sequencer: plays each queued run out one byte per transfer.
module xeu_back (
   input  logic                clock,
   input  logic                reset,
   input  xeu_pkg::run_type    q_run,
   input  logic                q_empty,
   output logic                q_pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_string_last,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   logic               valid_ff;
   xeu_pkg::run_type   run_ff;
   logic [2:0]         pos_ff;
   logic               taken, at_end, advance, load;

   assign rsp_empty       = !valid_ff;
   assign rsp_out_byte    = run_ff.bytes[pos_ff];
   assign at_end          = (pos_ff == 3'(run_ff.count - 3'd1));
   assign rsp_run_last    = at_end;
   assign rsp_string_last = at_end && run_ff.last;

   assign taken   = rsp_pop && valid_ff;
   assign advance = !valid_ff || (taken && at_end);
   assign load    = advance && !q_empty;
   assign q_pop   = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         pos_ff   <= '0;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end else if (taken) begin
         pos_ff <= pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= q_run;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (run_ff.count != 3'd0) && (run_ff.count <= 3'(xeu_pkg::MaxRun)))
      else $error("run length out of range");

   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (pos_ff < run_ff.count))
      else $error("byte position beyond run");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> valid_ff && $stable(pos_ff))
      else $error("stalled result moved");

endmodule

// File: rtl/xml_entity_unescaper.sv
// Top level of the streaming XML predefined entity decoder.
// Each run passes through a run queue slot and then the sequencer's run register before it shows.
// Throughput: one input byte per cycle while the run queue is not full and each byte yields at
//   most one result; the output sequencer sends one byte per cycle while rsp_pop is high.
// A short run queue between the matcher and the sequencer absorbs multi-byte flushes.
// Reset (synchronous, active high) clears the pending match and empties the queue.
module xml_entity_unescaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_last
);

   logic               q_push, q_full, q_pop, q_empty;
   xeu_pkg::run_type   q_in_run, q_out_run;

   // Hold off new bytes only while the run queue is full.
   assign req_full = q_full;

   // Front end: track the entity prefix and form the run each byte causes.
   xeu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_run       (q_in_run)
   );

   // Queue of runs decoupling the two sides.
   xeu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_run (q_in_run),
      .full     (q_full),
      .pop      (q_pop),
      .pop_run  (q_out_run),
      .empty    (q_empty)
   );

   // Back end: advance through each run one transfer at a time.
   xeu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_run           (q_out_run),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

endmodule
